// ===== design/positional_list_engine_assert.svh =====
// Assertion macros for the positional list engine port checker.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the list engine.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int FUNC_W    = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Request functions.
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // Cursor operations.
    localparam logic [2:0] CUR_HOLD  = 3'd0;
    localparam logic [2:0] CUR_COUNT = 3'd1;
    localparam logic [2:0] CUR_IDX   = 3'd2;
    localparam logic [2:0] CUR_ZERO  = 3'd3;
    localparam logic [2:0] CUR_INC   = 3'd4;
    localparam logic [2:0] CUR_DEC   = 3'd5;

    // Read address selects, relative to the cursor.
    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // Write data selects.
    localparam logic WD_RDATA = 1'b0;
    localparam logic WD_VALUE = 1'b1;

    // Output register sources.
    localparam logic OUT_SINGLE = 1'b0;
    localparam logic OUT_DUMP   = 1'b1;

    typedef struct packed {
        logic       req_load;
        logic       chk_load;
        logic [2:0] cur_op;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_sel;
        logic       rem_load;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
        logic       out_sel;
    } t_cmd;

    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic err;
        logic at_idx;
        logic at_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: bounded ordered list of signed 32-bit values.
//
// Requests arrive as words on the s_axis channel: tuser carries the function, tdata carries
// the 1-based position in bits [6:0] and the value in bits [38:7]. Results leave as words on
// the m_axis channel: tuser carries the status, tdata the element, tlast marks the final
// word of a request. Each request gives one word, except a dump of a non-empty list, which
// gives one word per stored element, front first.
// One request is handled at a time. The list lives in a RAM, and every shift step moves one
// entry by a registered read, then a write, so inserts and deletes shift every entry that
// lies behind the target. A dump reads one entry at a time into the output register,
// waiting while that word is not yet taken. Errors and inserts at the end shift no entries.
// The input is ready again as soon as the last result is in the output register, so the
// next request is taken while that word still waits for the receiver.
// When the receiver stalls, the output register holds its word and the engine waits with
// the next result; nothing is dropped.
// Reset (i_rst_n low at a clock edge) empties the list and clears the output valid flag;
// the RAM contents are left as they are, since only entries below the count are read.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // position [6:0], value [38:7], zero
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // func [2:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // element [31:0]
    output logic [ST_W-1:0]           m_axis_tuser,  // status [1:0]
    output logic                      m_axis_tlast
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic signed [VAL_W-1:0] req_value;
    logic signed [VAL_W-1:0] out_element;

    // Unpack the request word; the value field sits right above the position.
    assign req_value = signed'(s_axis_tdata[POS_W +: VAL_W]);

    ple_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_func  (s_axis_tuser),
        .i_req_pos   (s_axis_tdata[POS_W-1:0]),
        .i_req_value (req_value),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_status  (m_axis_tuser),
        .o_m_element (out_element),
        .o_m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = unsigned'(out_element);

endmodule

`default_nettype wire

// ===== design/ple_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ple_ctrl.sv =====
// Controller state machine that sequences checks, shifts, dumps and result hand-off.
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    output logic      o_s_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_DEL_RD  = 4'd4;
    localparam logic [3:0] S_DEL_CAP = 4'd5;
    localparam logic [3:0] S_DEL_CHK = 4'd6;
    localparam logic [3:0] S_DEL_WR  = 4'd7;
    localparam logic [3:0] S_DMP_RD  = 4'd8;
    localparam logic [3:0] S_DMP_OUT = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        // No word is taken while reset is held.
        o_s_ready = (r_state == S_IDLE) && i_rst_n;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.chk_load = 1'b1;
                if (i_sts.err) begin
                    n_state = S_EMIT;
                end else if (i_sts.is_ins) begin
                    o_cmd.cur_op = CUR_COUNT;
                    n_state      = S_INS_CHK;
                end else if (i_sts.is_del) begin
                    o_cmd.cur_op = CUR_IDX;
                    n_state      = S_DEL_RD;
                end else begin
                    o_cmd.cur_op = CUR_ZERO;
                    n_state      = S_DMP_RD;
                end
            end
            S_INS_CHK: begin
                if (i_sts.at_idx) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WD_VALUE;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WD_RDATA;
                o_cmd.cur_op = CUR_DEC;
                n_state      = S_INS_CHK;
            end
            S_DEL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                o_cmd.rem_load = 1'b1;
                n_state        = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (i_sts.at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WD_RDATA;
                o_cmd.cur_op = CUR_INC;
                n_state      = S_DEL_CHK;
            end
            S_DMP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DUMP;
                    if (i_sts.at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.cur_op = CUR_INC;
                        n_state      = S_DMP_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_SINGLE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ple_dp.sv =====
// Datapath: request registers, checks, cursor, element count, list RAM and output register.
`default_nettype none

module ple_dp
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic [FUNC_W-1:0]        i_req_func,
    input  wire logic [POS_W-1:0]         i_req_pos,
    input  wire logic signed [VAL_W-1:0]  i_req_value,
    input  wire logic                     i_m_ready,
    output logic                          o_m_valid,
    output logic [ST_W-1:0]               o_m_status,
    output logic signed [VAL_W-1:0]       o_m_element,
    output logic                          o_m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    logic [FUNC_W-1:0]       r_func;
    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_value;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_cursor;
    logic [VAL_W-1:0]        r_removed;
    logic [ST_W-1:0]         r_code;
    logic                    r_m_valid;
    logic [ST_W-1:0]         r_m_status;
    logic signed [VAL_W-1:0] r_m_element;
    logic                    r_m_last;

    logic [CW:0]        count_p1;
    logic [CW:0]        cur_p1;
    logic [CW-1:0]      cur_m1;
    logic [EW-1:0]      epos;
    logic [EW-1:0]      epos_m1;
    logic [CW-1:0]      idx;
    logic               is_ins;
    logic               is_del;
    logic               is_dump;
    logic               full;
    logic               empty;
    logic               ins_bad;
    logic               del_bad;
    logic [ST_W-1:0]    code;
    logic [AW-1:0]      ram_raddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [VAL_W-1:0]   ram_rdata;

    assign count_p1 = {1'b0, r_count} + (CW + 1)'(1);
    assign cur_p1   = {1'b0, r_cursor} + (CW + 1)'(1);
    assign cur_m1   = r_cursor - CW'(1);

    assign is_ins  = r_func inside {FN_INS_FRONT, FN_INS_POS, FN_INS_END};
    assign is_del  = r_func inside {FN_DEL_FRONT, FN_DEL_POS, FN_DEL_END};
    assign is_dump = (r_func == FN_DUMP);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);

    // Effective 1-based position for the insert and delete functions; zero for the others.
    always_comb begin
        case (r_func)
            FN_INS_FRONT, FN_DEL_FRONT: epos = EW'(1);
            FN_INS_POS, FN_DEL_POS:     epos = EW'(r_pos);
            FN_INS_END:                 epos = EW'(count_p1);
            FN_DEL_END:                 epos = EW'(r_count);
            default:                    epos = '0;
        endcase
    end

    assign epos_m1 = epos - EW'(1);
    assign idx     = epos_m1[CW-1:0];
    assign ins_bad = (epos == '0) || (epos > EW'(count_p1));
    assign del_bad = (epos == '0) || (epos > EW'(r_count));

    // Position is checked before capacity on inserts; emptiness first on deletes.
    always_comb begin
        code = ST_OK;
        if (is_ins) begin
            if (ins_bad) begin
                code = ST_INVALID;
            end else if (full) begin
                code = ST_FULL;
            end
        end else if (is_del) begin
            if (empty) begin
                code = ST_EMPTY;
            end else if (del_bad) begin
                code = ST_INVALID;
            end
        end else if (is_dump) begin
            if (empty) begin
                code = ST_EMPTY;
            end
        end else begin
            code = ST_INVALID;
        end
    end

    assign o_sts.is_ins   = is_ins;
    assign o_sts.is_del   = is_del;
    assign o_sts.err      = (code != ST_OK);
    assign o_sts.at_idx   = (r_cursor == idx);
    assign o_sts.at_end   = (cur_p1 == {1'b0, r_count});
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: ram_raddr = cur_m1[AW-1:0];
            RD_NEXT: ram_raddr = cur_p1[AW-1:0];
            default: ram_raddr = r_cursor[AW-1:0];
        endcase
    end

    assign ram_wdata = (i_cmd.wr_sel == WD_VALUE) ? unsigned'(r_value) : ram_rdata;

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_cursor[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_func  <= i_req_func;
            r_pos   <= i_req_pos;
            r_value <= i_req_value;
        end
        if (i_cmd.chk_load) begin
            r_code <= code;
        end
        if (i_cmd.rem_load) begin
            r_removed <= ram_rdata;
        end
        case (i_cmd.cur_op)
            CUR_COUNT: r_cursor <= r_count;
            CUR_IDX:   r_cursor <= idx;
            CUR_ZERO:  r_cursor <= '0;
            CUR_INC:   r_cursor <= r_cursor + CW'(1);
            CUR_DEC:   r_cursor <= cur_m1;
            default:   r_cursor <= r_cursor;
        endcase
        if (i_cmd.out_load) begin
            if (i_cmd.out_sel == OUT_DUMP) begin
                r_m_status  <= ST_OK;
                r_m_element <= signed'(ram_rdata);
                r_m_last    <= o_sts.at_end;
            end else begin
                r_m_status  <= r_code;
                r_m_element <= (r_code == ST_OK && is_del) ? signed'(r_removed) : '0;
                r_m_last    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid   = r_m_valid;
    assign o_m_status  = r_m_status;
    assign o_m_element = r_m_element;
    assign o_m_last    = r_m_last;

endmodule

`default_nettype wire

// ===== design/ple_chk.sv =====
// Port-level checker for the positional list engine, bound to the top level.
`default_nettype none

`include "positional_list_engine_assert.svh"

module ple_chk
    import ple_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [FUNC_W-1:0]    s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [ST_W-1:0]      m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // A stalled result word stays in place.
    `PLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result word changed")

    // Error results carry a zero element and close their request.
    `PLE_ASSERT_NOW(a_err_word, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tlast && m_axis_tdata == '0, "error result with element or without last")

    // A request is taken only when the previous one has been worked off.
    `PLE_ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in work")

endmodule

bind positional_list_engine ple_chk u_ple_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/positional_list_engine_checker.sv =====
// Checker for the positional list engine: tracks the list contents and compares result words.
module positional_list_engine_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // position [6:0], value [38:7], zero
    input  logic [FUNC_W-1:0]    i_s_tuser,   // func [2:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // element [31:0]
    input  logic [ST_W-1:0]      i_m_tuser,   // status [1:0]
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_length
);

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] element;
        logic             last;
    } t_word;

    // Front of the list is entry 0.
    logic [VAL_W-1:0] list_contents[$];
    t_word            awaited_words[$];
    int               mismatches = 0;

    function automatic t_word single_word(logic [ST_W-1:0] status, logic [VAL_W-1:0] element);
        t_word w;
        w.status  = status;
        w.element = element;
        w.last    = 1'b1;
        return w;
    endfunction

    task automatic insert_at(int pos, logic [VAL_W-1:0] value);
        // The position check comes before the full check.
        if (pos < 1 || pos > list_contents.size() + 1) begin
            awaited_words.push_back(single_word(ST_INVALID, '0));
        end else if (list_contents.size() >= CAPACITY) begin
            awaited_words.push_back(single_word(ST_FULL, '0));
        end else begin
            list_contents.insert(pos - 1, value);
            awaited_words.push_back(single_word(ST_OK, '0));
        end
    endtask

    task automatic delete_at(int pos);
        logic [VAL_W-1:0] removed;
        // An empty list is reported before a bad position.
        if (list_contents.size() == 0) begin
            awaited_words.push_back(single_word(ST_EMPTY, '0));
        end else if (pos < 1 || pos > list_contents.size()) begin
            awaited_words.push_back(single_word(ST_INVALID, '0));
        end else begin
            removed = list_contents[pos - 1];
            list_contents.delete(pos - 1);
            awaited_words.push_back(single_word(ST_OK, removed));
        end
    endtask

    task automatic apply_list_request(logic [FUNC_W-1:0] fn, int pos, logic [VAL_W-1:0] value);
        int    n;
        t_word w;
        n = list_contents.size();
        case (fn)
            FN_INS_FRONT: insert_at(1, value);
            FN_INS_POS:   insert_at(pos, value);
            FN_INS_END:   insert_at(n + 1, value);
            FN_DEL_FRONT: delete_at(1);
            FN_DEL_POS:   delete_at(pos);
            FN_DEL_END:   delete_at(n);
            FN_DUMP: begin
                if (n == 0) begin
                    awaited_words.push_back(single_word(ST_EMPTY, '0));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        w.status  = ST_OK;
                        w.element = list_contents[i];
                        w.last    = (i == n - 1);
                        awaited_words.push_back(w);
                    end
                end
            end
            default: awaited_words.push_back(single_word(ST_INVALID, '0));
        endcase
    endtask

    task automatic report_word(string why, t_word exp_word, t_word got_word);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected status %0d element %0d last %0b, got status %0d element %0d last %0b",
                     $realtime, why, exp_word.status, $signed(exp_word.element), exp_word.last,
                     got_word.status, $signed(got_word.element), got_word.last);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_word got_word;
        t_word exp_word;
        if (!i_rst_n) begin
            list_contents.delete();
            awaited_words.delete();
        end else begin
            // Results first: a request taken at this edge cannot have produced a word yet.
            if (i_m_tvalid && i_m_tready) begin
                got_word.status  = i_m_tuser;
                got_word.element = i_m_tdata;
                got_word.last    = i_m_tlast;
                if (awaited_words.size() == 0) begin
                    report_word("word with nothing awaited", '0, got_word);
                end else begin
                    exp_word = awaited_words.pop_front();
                    if (got_word.status !== exp_word.status ||
                        got_word.element !== exp_word.element ||
                        got_word.last !== exp_word.last) begin
                        report_word("word mismatch", exp_word, got_word);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_list_request(i_s_tuser, int'(i_s_tdata[POS_W-1:0]),
                                   i_s_tdata[POS_W+VAL_W-1:POS_W]);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_words.size();
        o_length     <= list_contents.size();
    end

endmodule

// ===== dv/positional_list_engine_tb.sv =====
// Testbench top for the positional list engine: request stimulus, output stalls and verdict.
module positional_list_engine_tb;
    import ple_pkg::*;

    // The one selector that names no function; the engine must answer it as invalid.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    localparam int RANDOM_REQUESTS = 250;
    // Longest legal silence: the long output hold plus a full-length shift, with margin.
    localparam int IDLE_LIMIT      = 4000;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 80;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // position [6:0], value [38:7], zero
    logic [FUNC_W-1:0]    s_axis_tuser;   // func [2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // element [31:0]
    logic [ST_W-1:0]      m_axis_tuser;   // status [1:0]
    logic                 m_axis_tlast;

    int fail_count;
    int pending_words;
    int list_length;

    // Knobs shared between the request side and the result side.
    bit send_gaps_on;
    bit recv_stalls_on;
    bit long_hold_req;

    positional_list_engine #(
        .CAPACITY(CAPACITY_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    positional_list_engine_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_length     (list_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap before a request word: mostly none or a few cycles, now and then a long one.
    function automatic int pick_send_gap();
        int r;
        if (!send_gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Presents one request word at a falling edge and returns at the falling edge after the
    // rising edge where it was taken. With no gap, tvalid simply stays high for the next word.
    task automatic offer_request(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] value);
        int gap;
        gap = pick_send_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = fn;
        s_axis_tdata  = {1'b0, value, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // One random request shaped by the current phase. Positions are mostly legal for the
    // list length the checker reports, so positional inserts and deletes reach deep
    // entries; the rest span the whole field to hit the invalid cases.
    task automatic random_request(t_phase ph);
        int               r;
        int               n;
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        n = list_length;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   r = (r < 80) ? 0 : (r < 90) ? 1 : (r < 95) ? 2 : 3;
            PH_SHRINK: r = (r < 10) ? 0 : (r < 90) ? 1 : (r < 95) ? 2 : 3;
            default:   r = (r < 40) ? 0 : (r < 80) ? 1 : (r < 94) ? 2 : 3;
        endcase
        case (r)
            0: begin
                case ($urandom_range(0, 2))
                    0:       fn = FN_INS_FRONT;
                    1:       fn = FN_INS_POS;
                    default: fn = FN_INS_END;
                endcase
            end
            1: begin
                case ($urandom_range(0, 2))
                    0:       fn = FN_DEL_FRONT;
                    1:       fn = FN_DEL_POS;
                    default: fn = FN_DEL_END;
                endcase
            end
            2:       fn = FN_DUMP;
            default: fn = FN_UNUSED;
        endcase
        if ($urandom_range(0, 99) < 15) begin
            pos = POS_W'($urandom_range(0, 127));
        end else if (fn == FN_INS_POS) begin
            pos = POS_W'($urandom_range(1, n + 1));
        end else if (fn == FN_DEL_POS) begin
            pos = POS_W'($urandom_range(1, (n == 0) ? 1 : n));
        end else begin
            pos = POS_W'($urandom_range(0, 127));
        end
        if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'h0000_0000;
                default: value = 32'hFFFF_FFFF;
            endcase
        end else begin
            value = $urandom;
        end
        offer_request(fn, pos, value);
    endtask

    // Result side. The engine holds its output word while tready is low, so stalls of any
    // length are legal. A long hold, once requested, is counted out here while the request
    // side keeps offering words, so the output register stays full and the engine stops taking requests.
    initial begin : result_side
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (recv_stalls_on && $urandom_range(0, 9) < 3) begin
                m_axis_tready = 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog: the run fails if neither channel moves a word for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : request_side
        int     issued;
        int     steps;
        int     budget;
        int     tail;
        t_phase ph;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = FN_INS_FRONT;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        long_hold_req  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Every removal path and the invalid insert positions are tried on an empty
        // list first, then a short list is built with the extreme values and taken apart again.
        offer_request(FN_DUMP,      7'd0,   32'h0000_0000);  // dump of an empty list
        offer_request(FN_DEL_FRONT, 7'd0,   32'h0000_0000);  // deletes on an empty list
        offer_request(FN_DEL_POS,   7'd1,   32'h0000_0000);
        offer_request(FN_DEL_END,   7'd127, 32'hFFFF_FFFF);
        offer_request(FN_INS_POS,   7'd0,   32'h1234_5678);  // position zero is invalid
        offer_request(FN_INS_POS,   7'd2,   32'h1234_5678);  // past count+1 on empty list
        offer_request(FN_INS_FRONT, 7'd0,   32'h7FFF_FFFF);
        offer_request(FN_INS_END,   7'd0,   32'h8000_0000);
        offer_request(FN_INS_POS,   7'd2,   32'h0000_0000);  // into the middle
        offer_request(FN_INS_POS,   7'd4,   32'hFFFF_FFFF);  // at count+1, the end
        offer_request(FN_INS_POS,   7'd127, 32'h5555_5555);  // far past the end
        offer_request(FN_UNUSED,    7'd3,   32'hAAAA_AAAA);  // unused selector
        offer_request(FN_DUMP,      7'd0,   32'h0000_0000);
        offer_request(FN_DEL_POS,   7'd0,   32'h0000_0000);  // position zero
        offer_request(FN_DEL_POS,   7'd5,   32'h0000_0000);  // one past the count
        offer_request(FN_DEL_POS,   7'd127, 32'h0000_0000);
        offer_request(FN_DEL_POS,   7'd2,   32'h0000_0000);  // from the middle
        offer_request(FN_DEL_FRONT, 7'd0,   32'h0000_0000);
        offer_request(FN_DEL_END,   7'd0,   32'h0000_0000);
        offer_request(FN_INS_POS,   7'd1,   32'hAAAA_AAAA);  // positional insert at front
        offer_request(FN_DUMP,      7'd0,   32'h0000_0000);
        offer_request(FN_DEL_POS,   7'd2,   32'h0000_0000);  // the last entry by position
        offer_request(FN_DEL_POS,   7'd1,   32'h0000_0000);  // leaves the list empty
        offer_request(FN_INS_FRONT, 7'd0,   32'h5555_5555);

        // Random part in phases, the first one a grow phase. Grow phases mostly insert and end at
        // the latest after four requests on a full list, so inserts into a full list can be seen;
        // shrink phases mostly delete and end likewise on the empty list. Mixed phases wander between.
        issued = 0;
        ph     = PH_GROW;
        while (issued < RANDOM_REQUESTS) begin
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            recv_stalls_on = ($urandom_range(0, 3) != 0);
            budget = (ph == PH_MIXED) ? $urandom_range(20, 40) : 70;
            steps  = 0;
            tail   = 0;
            while (steps < budget && tail < 4 && issued < RANDOM_REQUESTS) begin
                if ((ph == PH_GROW && list_length == CAPACITY_DEF) ||
                    (ph == PH_SHRINK && list_length == 0)) begin
                    tail++;
                end
                // Once, early on, the result side holds off for a long stretch.
                if (issued == 40) begin
                    long_hold_req = 1'b1;
                end
                random_request(ph);
                steps++;
                issued++;
            end
            case ($urandom_range(0, 2))
                0:       ph = PH_GROW;
                1:       ph = PH_SHRINK;
                default: ph = PH_MIXED;
            endcase
        end
        s_axis_tvalid = 1'b0;

        // Drain: every awaited word must arrive, then stray words get a chance to show up.
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_words == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
